// ===== src/dllc_pkg.sv =====
// dllc_pkg: types, constants and codes shared by the linked list manager.
// Used by dllc_ctrl, dllc_dp and doubly_linked_list_with_cursor.
package dllc_pkg;

  localparam int NODE_COUNT = 64;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int PTR_W      = $clog2(NODE_COUNT + 1);
  localparam int DATA_W     = 32;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

  typedef enum logic [3:0] {
    K_CLEAR      = 4'd0,
    K_INS_HEAD   = 4'd1,
    K_INS_TAIL   = 4'd2,
    K_CUR_HEAD   = 4'd3,
    K_CUR_TAIL   = 4'd4,
    K_DEL_HEAD   = 4'd5,
    K_DEL_TAIL   = 4'd6,
    K_DEL_AFTER  = 4'd7,
    K_DEL_BEFORE = 4'd8,
    K_INS_AFTER  = 4'd9,
    K_INS_BEFORE = 4'd10,
    K_OVERWRITE  = 4'd11,
    K_NEXT       = 4'd12,
    K_PREV       = 4'd13,
    K_READ       = 4'd14
  } kind_t;

  typedef struct packed {
    logic [3:0]               kind;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     pool_full_error;
    logic                     head_valid;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
    logic                     cursor_valid;
    logic signed [DATA_W-1:0] cursor_value;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ALLOC_CAP, S_ALLOCED, S_CAPN, S_CAPX, S_WR_A, S_WR_B, S_OUT
  } state_t;

  // Memory address sources
  typedef enum logic [2:0] {
    A_HEAD, A_TAIL, A_CUR, A_FREE, A_N, A_X, A_NEXT_RD, A_PREV_RD
  } addr_sel_t;

  // Link write data sources
  typedef enum logic [2:0] {
    W_NIL, W_FREE, W_HEAD, W_TAIL, W_CUR, W_N, W_X
  } wsel_t;

  typedef enum logic [1:0] {
    CAP_NONE, CAP_NEXT, CAP_PREV
  } cap_sel_t;

  typedef struct packed {
    logic      accept;
    logic      set_err;
    logic      alloc_fresh;
    logic      alloc_free;
    logic      next_we;
    logic      next_re;
    addr_sel_t next_addr;
    wsel_t     next_wsel;
    logic      prev_we;
    logic      prev_re;
    addr_sel_t prev_addr;
    wsel_t     prev_wsel;
    logic      data_we;
    logic      data_re;
    addr_sel_t data_addr;
    cap_sel_t  cap_n;
    cap_sel_t  cap_x;
    logic      commit;
    kind_t     kind;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic head_nil;
    logic tail_nil;
    logic cur_nil;
    logic free_nil;
    logic fresh_full;
    logic cur_is_head;
    logic cur_is_tail;
    logic x_nil;
  } status_t;

endpackage

// ===== src/dllc_ram.sv =====
// dllc_ram: generic single-port RAM with registered read data.
// No dependencies.
module dllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data held until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/dllc_ctrl.sv =====
// dllc_ctrl: sequencer for the list manager; issues memory and pointer commands.
// Depends on dllc_pkg.
module dllc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [3:0]       req_kind,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  dllc_pkg::status_t st,
  output dllc_pkg::cmd_t   cmd
);
  import dllc_pkg::*;

  state_t state, state_next;
  kind_t  kind, kind_next;
  logic   rsp_valid_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_READ;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      kind      <= kind_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // Latch the operation code and track the output register
  always_comb begin
    kind_next = kind;
    if (req_valid && req_ready) begin
      kind_next = kind_t'(req_kind);
    end
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_START;
      end
      S_START: begin
        unique case (kind)
          K_INS_HEAD, K_INS_TAIL, K_INS_AFTER, K_INS_BEFORE: begin
            if ((kind == K_INS_AFTER || kind == K_INS_BEFORE) && st.cur_nil) begin
              state_next = S_OUT;
            end else if (!st.free_nil) begin
              state_next = S_ALLOC_CAP;
            end else if (!st.fresh_full) begin
              state_next = S_ALLOCED;
            end else begin
              state_next = S_OUT;
            end
          end
          K_DEL_HEAD: state_next = st.head_nil ? S_OUT : S_CAPX;
          K_DEL_TAIL: state_next = st.tail_nil ? S_OUT : S_CAPX;
          K_DEL_AFTER: state_next = (st.cur_nil || st.cur_is_tail) ? S_OUT : S_CAPN;
          K_DEL_BEFORE: state_next = (st.cur_nil || st.cur_is_head) ? S_OUT : S_CAPN;
          K_NEXT, K_PREV: state_next = st.cur_nil ? S_OUT : S_CAPX;
          default: state_next = S_OUT;
        endcase
      end
      S_ALLOC_CAP: state_next = S_ALLOCED;
      S_ALLOCED: begin
        if (kind == K_INS_AFTER || kind == K_INS_BEFORE) state_next = S_CAPX;
        else state_next = S_WR_A;
      end
      S_CAPN: state_next = S_CAPX;
      S_CAPX: begin
        if (kind == K_NEXT || kind == K_PREV) state_next = S_WR_B;
        else state_next = S_WR_A;
      end
      S_WR_A: state_next = S_WR_B;
      S_WR_B: state_next = S_OUT;
      S_OUT: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = kind;
    unique case (state)
      S_IDLE: begin
        cmd.accept = req_valid;
      end
      S_START: begin
        unique case (kind)
          K_CLEAR: begin
            // splice the whole list onto the free chain
            cmd.next_we   = !st.head_nil;
            cmd.next_addr = A_TAIL;
            cmd.next_wsel = W_FREE;
            cmd.commit    = 1'b1;
          end
          K_INS_HEAD, K_INS_TAIL, K_INS_AFTER, K_INS_BEFORE: begin
            if (!((kind == K_INS_AFTER || kind == K_INS_BEFORE) && st.cur_nil)) begin
              if (!st.free_nil) begin
                cmd.next_re   = 1'b1;
                cmd.next_addr = A_FREE;
              end else if (!st.fresh_full) begin
                cmd.alloc_fresh = 1'b1;
              end else begin
                cmd.set_err = 1'b1;
              end
            end
          end
          K_CUR_HEAD, K_CUR_TAIL: cmd.commit = 1'b1;
          K_DEL_HEAD: begin
            cmd.next_re   = !st.head_nil;
            cmd.next_addr = A_HEAD;
          end
          K_DEL_TAIL: begin
            cmd.prev_re   = !st.tail_nil;
            cmd.prev_addr = A_TAIL;
          end
          K_DEL_AFTER, K_NEXT: begin
            cmd.next_re   = !st.cur_nil;
            cmd.next_addr = A_CUR;
          end
          K_DEL_BEFORE, K_PREV: begin
            cmd.prev_re   = !st.cur_nil;
            cmd.prev_addr = A_CUR;
          end
          K_OVERWRITE: begin
            cmd.data_we   = !st.cur_nil;
            cmd.data_addr = A_CUR;
            cmd.commit    = !st.cur_nil;
          end
          default: ;
        endcase
      end
      S_ALLOC_CAP: begin
        cmd.alloc_free = 1'b1;
      end
      S_ALLOCED: begin
        if (kind == K_INS_AFTER) begin
          cmd.next_re   = 1'b1;
          cmd.next_addr = A_CUR;
        end else if (kind == K_INS_BEFORE) begin
          cmd.prev_re   = 1'b1;
          cmd.prev_addr = A_CUR;
        end
      end
      S_CAPN: begin
        // follow the removed node's link one step further
        if (kind == K_DEL_AFTER) begin
          cmd.cap_n     = CAP_NEXT;
          cmd.next_re   = 1'b1;
          cmd.next_addr = A_NEXT_RD;
        end else begin
          cmd.cap_n     = CAP_PREV;
          cmd.prev_re   = 1'b1;
          cmd.prev_addr = A_PREV_RD;
        end
      end
      S_CAPX: begin
        if (kind == K_DEL_TAIL || kind == K_DEL_BEFORE || kind == K_INS_BEFORE ||
            kind == K_PREV) begin
          cmd.cap_x     = CAP_PREV;
          cmd.data_addr = A_PREV_RD;
        end else begin
          cmd.cap_x     = CAP_NEXT;
          cmd.data_addr = A_NEXT_RD;
        end
        cmd.data_re = (kind == K_NEXT || kind == K_PREV);
      end
      S_WR_A: begin
        unique case (kind)
          K_INS_HEAD, K_INS_TAIL, K_INS_AFTER, K_INS_BEFORE: begin
            cmd.data_we   = 1'b1;
            cmd.data_addr = A_N;
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_N;
            cmd.prev_we   = 1'b1;
            cmd.prev_addr = A_N;
            unique case (kind)
              K_INS_HEAD: begin
                cmd.next_wsel = W_HEAD;
                cmd.prev_wsel = W_NIL;
              end
              K_INS_TAIL: begin
                cmd.next_wsel = W_NIL;
                cmd.prev_wsel = W_TAIL;
              end
              K_INS_AFTER: begin
                cmd.next_wsel = W_X;
                cmd.prev_wsel = W_CUR;
              end
              default: begin
                cmd.next_wsel = W_CUR;
                cmd.prev_wsel = W_X;
              end
            endcase
          end
          K_DEL_HEAD: begin
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_HEAD;
            cmd.next_wsel = W_FREE;
            cmd.prev_we   = !st.x_nil;
            cmd.prev_addr = A_X;
            cmd.prev_wsel = W_NIL;
            cmd.data_re   = 1'b1;
            cmd.data_addr = A_X;
          end
          K_DEL_TAIL: begin
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_TAIL;
            cmd.next_wsel = W_FREE;
            cmd.data_re   = 1'b1;
            cmd.data_addr = A_X;
          end
          K_DEL_AFTER: begin
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_CUR;
            cmd.next_wsel = W_X;
            cmd.prev_we   = !st.x_nil;
            cmd.prev_addr = A_X;
            cmd.prev_wsel = W_CUR;
          end
          K_DEL_BEFORE: begin
            cmd.prev_we   = 1'b1;
            cmd.prev_addr = A_CUR;
            cmd.prev_wsel = W_X;
            cmd.next_we   = !st.x_nil;
            cmd.next_addr = A_X;
            cmd.next_wsel = W_CUR;
          end
          default: ;
        endcase
      end
      S_WR_B: begin
        cmd.commit = 1'b1;
        unique case (kind)
          K_INS_HEAD: begin
            cmd.prev_we   = !st.head_nil;
            cmd.prev_addr = A_HEAD;
            cmd.prev_wsel = W_N;
          end
          K_INS_TAIL: begin
            cmd.next_we   = !st.tail_nil;
            cmd.next_addr = A_TAIL;
            cmd.next_wsel = W_N;
          end
          K_INS_AFTER: begin
            cmd.prev_we   = !st.x_nil;
            cmd.prev_addr = A_X;
            cmd.prev_wsel = W_N;
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_CUR;
            cmd.next_wsel = W_N;
          end
          K_INS_BEFORE: begin
            cmd.next_we   = !st.x_nil;
            cmd.next_addr = A_X;
            cmd.next_wsel = W_N;
            cmd.prev_we   = 1'b1;
            cmd.prev_addr = A_CUR;
            cmd.prev_wsel = W_N;
          end
          K_DEL_TAIL: begin
            cmd.next_we   = !st.x_nil;
            cmd.next_addr = A_X;
            cmd.next_wsel = W_NIL;
          end
          K_DEL_AFTER, K_DEL_BEFORE: begin
            // freed node joins the free chain
            cmd.next_we   = 1'b1;
            cmd.next_addr = A_N;
            cmd.next_wsel = W_FREE;
          end
          default: ;
        endcase
      end
      S_OUT: begin
        cmd.load_out = !rsp_valid || rsp_ready;
      end
      default: ;
    endcase
  end

  // Checks
  a_load_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while a result waits");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_START))
    else $error("accepted transaction did not start");

  a_err_no_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.set_err && (cmd.commit || cmd.alloc_fresh || cmd.next_re)))
    else $error("pool full error raised alongside a list update");

endmodule

// ===== src/dllc_dp.sv =====
// dllc_dp: node pool memories, list pointers, cached end and cursor values and result register.
// Depends on dllc_pkg and dllc_ram.
module dllc_dp (
  input  logic              clk,
  input  logic              rst,
  input  dllc_pkg::req_t    req,
  input  dllc_pkg::cmd_t    cmd,
  output dllc_pkg::status_t st,
  output dllc_pkg::rsp_t    rsp
);
  import dllc_pkg::*;

  logic [PTR_W-1:0] head, tail, cur, free_head, fresh, n_ptr, x_ptr;
  logic [PTR_W-1:0] head_next, tail_next, cur_next, free_next, fresh_next;
  logic [PTR_W-1:0] n_next, x_next;
  logic signed [DATA_W-1:0] head_val, tail_val, cur_val, value;
  logic signed [DATA_W-1:0] head_val_next, tail_val_next, cur_val_next, value_next;
  logic err, err_next;
  rsp_t rsp_next;

  logic [PTR_W-1:0]  next_rdata, prev_rdata, next_wdata, prev_wdata;
  logic [DATA_W-1:0] data_rdata;
  logic [PTR_W-1:0]  next_addr, prev_addr, data_addr;
  logic              x_valid;

  function automatic logic [PTR_W-1:0] pick_addr(addr_sel_t s, logic [PTR_W-1:0] h,
      logic [PTR_W-1:0] t, logic [PTR_W-1:0] c, logic [PTR_W-1:0] f,
      logic [PTR_W-1:0] n, logic [PTR_W-1:0] x, logic [PTR_W-1:0] nr,
      logic [PTR_W-1:0] pr);
    logic [PTR_W-1:0] r;
    unique case (s)
      A_HEAD:    r = h;
      A_TAIL:    r = t;
      A_CUR:     r = c;
      A_FREE:    r = f;
      A_N:       r = n;
      A_X:       r = x;
      A_NEXT_RD: r = nr;
      A_PREV_RD: r = pr;
      default:   r = h;
    endcase
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] pick_link(wsel_t s, logic [PTR_W-1:0] f,
      logic [PTR_W-1:0] h, logic [PTR_W-1:0] t, logic [PTR_W-1:0] c,
      logic [PTR_W-1:0] n, logic [PTR_W-1:0] x);
    logic [PTR_W-1:0] r;
    unique case (s)
      W_NIL:   r = NIL;
      W_FREE:  r = f;
      W_HEAD:  r = h;
      W_TAIL:  r = t;
      W_CUR:   r = c;
      W_N:     r = n;
      W_X:     r = x;
      default: r = NIL;
    endcase
    return r;
  endfunction

  // Address and write data selection
  assign next_addr  = pick_addr(cmd.next_addr, head, tail, cur, free_head, n_ptr, x_ptr,
                                next_rdata, prev_rdata);
  assign prev_addr  = pick_addr(cmd.prev_addr, head, tail, cur, free_head, n_ptr, x_ptr,
                                next_rdata, prev_rdata);
  assign data_addr  = pick_addr(cmd.data_addr, head, tail, cur, free_head, n_ptr, x_ptr,
                                next_rdata, prev_rdata);
  assign next_wdata = pick_link(cmd.next_wsel, free_head, head, tail, cur, n_ptr, x_ptr);
  assign prev_wdata = pick_link(cmd.prev_wsel, free_head, head, tail, cur, n_ptr, x_ptr);

  // Node pool memories
  dllc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (cmd.next_we),
    .re    (cmd.next_re),
    .addr  (next_addr[IDX_W-1:0]),
    .wdata (next_wdata),
    .rdata (next_rdata)
  );

  dllc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (cmd.prev_we),
    .re    (cmd.prev_re),
    .addr  (prev_addr[IDX_W-1:0]),
    .wdata (prev_wdata),
    .rdata (prev_rdata)
  );

  dllc_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (cmd.data_we),
    .re    (cmd.data_re),
    .addr  (data_addr[IDX_W-1:0]),
    .wdata (value),
    .rdata (data_rdata)
  );

  // Status to the sequencer
  assign x_valid        = (x_ptr != NIL);
  assign st.head_nil    = (head == NIL);
  assign st.tail_nil    = (tail == NIL);
  assign st.cur_nil     = (cur == NIL);
  assign st.free_nil    = (free_head == NIL);
  assign st.fresh_full  = (fresh == NIL);
  assign st.cur_is_head = (cur == head);
  assign st.cur_is_tail = (cur == tail);
  assign st.x_nil       = !x_valid;

  // Pointer, cached value and result updates
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    cur_next      = cur;
    free_next     = free_head;
    fresh_next    = fresh;
    n_next        = n_ptr;
    x_next        = x_ptr;
    head_val_next = head_val;
    tail_val_next = tail_val;
    cur_val_next  = cur_val;
    value_next    = value;
    err_next      = err;
    rsp_next      = rsp;

    if (cmd.accept) begin
      value_next = req.value;
      err_next   = 1'b0;
    end
    if (cmd.set_err) err_next = 1'b1;
    if (cmd.alloc_fresh) begin
      n_next     = fresh;
      fresh_next = fresh + PTR_W'(1);
    end
    if (cmd.alloc_free) begin
      n_next    = free_head;
      free_next = next_rdata;
    end
    case (cmd.cap_n)
      CAP_NEXT: n_next = next_rdata;
      CAP_PREV: n_next = prev_rdata;
      default:  ;
    endcase
    case (cmd.cap_x)
      CAP_NEXT: x_next = next_rdata;
      CAP_PREV: x_next = prev_rdata;
      default:  ;
    endcase

    if (cmd.commit) begin
      unique case (cmd.kind)
        K_CLEAR: begin
          if (head != NIL) free_next = head;
          head_next     = NIL;
          tail_next     = NIL;
          cur_next      = NIL;
          head_val_next = '0;
          tail_val_next = '0;
          cur_val_next  = '0;
        end
        K_INS_HEAD: begin
          head_next     = n_ptr;
          head_val_next = value;
          if (head == NIL) begin
            tail_next     = n_ptr;
            tail_val_next = value;
          end
        end
        K_INS_TAIL: begin
          tail_next     = n_ptr;
          tail_val_next = value;
          if (tail == NIL) begin
            head_next     = n_ptr;
            head_val_next = value;
          end
        end
        K_CUR_HEAD: begin
          cur_next     = head;
          cur_val_next = head_val;
        end
        K_CUR_TAIL: begin
          cur_next     = tail;
          cur_val_next = tail_val;
        end
        K_DEL_HEAD: begin
          free_next     = head;
          head_next     = x_ptr;
          head_val_next = x_valid ? data_rdata : '0;
          if (cur == head) begin
            cur_next     = NIL;
            cur_val_next = '0;
          end
          if (!x_valid) begin
            tail_next     = NIL;
            tail_val_next = '0;
          end
        end
        K_DEL_TAIL: begin
          free_next     = tail;
          tail_next     = x_ptr;
          tail_val_next = x_valid ? data_rdata : '0;
          if (cur == tail) begin
            cur_next     = NIL;
            cur_val_next = '0;
          end
          if (!x_valid) begin
            head_next     = NIL;
            head_val_next = '0;
          end
        end
        K_DEL_AFTER: begin
          free_next = n_ptr;
          if (!x_valid) begin
            tail_next     = cur;
            tail_val_next = cur_val;
          end
        end
        K_DEL_BEFORE: begin
          free_next = n_ptr;
          if (!x_valid) begin
            head_next     = cur;
            head_val_next = cur_val;
          end
        end
        K_INS_AFTER: begin
          if (!x_valid) begin
            tail_next     = n_ptr;
            tail_val_next = value;
          end
        end
        K_INS_BEFORE: begin
          if (!x_valid) begin
            head_next     = n_ptr;
            head_val_next = value;
          end
        end
        K_OVERWRITE: begin
          cur_val_next = value;
          if (cur == head) head_val_next = value;
          if (cur == tail) tail_val_next = value;
        end
        K_NEXT, K_PREV: begin
          cur_next     = x_ptr;
          cur_val_next = x_valid ? data_rdata : '0;
        end
        default: ;
      endcase
    end

    if (cmd.load_out) begin
      rsp_next.pool_full_error = err;
      rsp_next.head_valid      = (head != NIL);
      rsp_next.head_value      = head_val;
      rsp_next.tail_value      = tail_val;
      rsp_next.cursor_valid    = (cur != NIL);
      rsp_next.cursor_value    = cur_val;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      head_val  <= '0;
      tail_val  <= '0;
      cur_val   <= '0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      cur       <= cur_next;
      free_head <= free_next;
      fresh     <= fresh_next;
      head_val  <= head_val_next;
      tail_val  <= tail_val_next;
      cur_val   <= cur_val_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_ptr <= n_next;
    x_ptr <= x_next;
    value <= value_next;
    err   <= err_next;
    rsp   <= rsp_next;
  end

  // Checks
  a_fresh_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_fresh |-> (fresh != NIL))
    else $error("fresh node taken from an exhausted pool");

  a_free_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_free |-> (free_head != NIL))
    else $error("node taken from an empty free chain");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (tail == NIL))
    else $error("head and tail disagree on an empty list");

endmodule

// ===== src/doubly_linked_list_with_cursor.sv =====
// doubly_linked_list_with_cursor: top level of the linked list manager.
// Depends on dllc_pkg, dllc_ctrl, dllc_dp (and dllc_ram through dllc_dp).
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   request | req_valid, req_ready | req: kind, value
//   result  | rsp_valid, rsp_ready | rsp: pool_full_error, head/tail/cursor
//
// One transaction at a time: the path from acceptance to the result register is set by
// the number of single-port node memory accesses (allocate, follow links, relink in
// states S_WR_A and S_WR_B), and the sequencer returns to idle before the next request.
// Reads and moves to an end go from the start state straight to the output state.
// Reset clears the head, tail, cursor and free pointers and the fresh counter; the node memories need no clearing.
// A waiting result does not block the next request until its own result is due.
module doubly_linked_list_with_cursor (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dllc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dllc_pkg::rsp_t rsp
);
  import dllc_pkg::*;

  cmd_t    cmd;
  status_t st;

  dllc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_kind  (req.kind),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .cmd       (cmd)
  );

  dllc_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .st  (st),
    .rsp (rsp)
  );

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for the doubly linked list manager.
// Depends on dllc_pkg and doubly_linked_list_with_cursor; holds its own list predictor.
module tb;
  import dllc_pkg::*;

  localparam int NN = NODE_COUNT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  doubly_linked_list_with_cursor i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Predictor state: node pool, ends, cursor and free chain
  logic [31:0] pool_val [NN];
  int          pool_prv [NN];
  int          pool_nxt [NN];
  int          head_p, tail_p, cur_p, free_p, fresh_n;

  rsp_t  pending_q [$];
  int    fail_n = 0;
  bit    no_idle = 1'b0;
  bit    hold_rx = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL doubly_linked_list_with_cursor");
    $finish;
  end

  function automatic bit is_node(int p);
    return p >= 0 && p < NN;
  endfunction

  function automatic int list_len();
    int c;
    int p;
    c = 0;
    p = head_p;
    while (is_node(p)) begin
      c++;
      p = pool_nxt[p];
    end
    return c;
  endfunction

  function automatic int grab_node();
    int n;
    if (is_node(free_p)) begin
      n = free_p;
      free_p = pool_nxt[n];
      return n;
    end
    if (fresh_n < NN) begin
      fresh_n++;
      return fresh_n - 1;
    end
    return NN;
  endfunction

  function automatic void drop_node(int n);
    pool_nxt[n] = free_p;
    free_p = n;
  endfunction

  // Apply one list operation and return the resulting report
  function automatic rsp_t list_apply(logic [3:0] k, logic [31:0] v);
    rsp_t r;
    int n;
    int x;
    r = '0;
    case (k)
      K_CLEAR: begin
        if (is_node(head_p)) begin
          pool_nxt[tail_p] = free_p;
          free_p = head_p;
        end
        head_p = NN; tail_p = NN; cur_p = NN;
      end
      K_INS_HEAD, K_INS_TAIL: begin
        n = grab_node();
        if (!is_node(n)) r.pool_full_error = 1'b1;
        else begin
          pool_val[n] = v;
          if (k == K_INS_HEAD) begin
            pool_prv[n] = NN; pool_nxt[n] = head_p;
            if (is_node(head_p)) pool_prv[head_p] = n; else tail_p = n;
            head_p = n;
          end else begin
            pool_nxt[n] = NN; pool_prv[n] = tail_p;
            if (is_node(tail_p)) pool_nxt[tail_p] = n; else head_p = n;
            tail_p = n;
          end
        end
      end
      K_CUR_HEAD: cur_p = head_p;
      K_CUR_TAIL: cur_p = tail_p;
      K_DEL_HEAD: if (is_node(head_p)) begin
        if (cur_p == head_p) cur_p = NN;
        x = pool_nxt[head_p];
        if (is_node(x)) pool_prv[x] = NN; else tail_p = NN;
        drop_node(head_p);
        head_p = x;
      end
      K_DEL_TAIL: if (is_node(tail_p)) begin
        if (cur_p == tail_p) cur_p = NN;
        x = pool_prv[tail_p];
        if (is_node(x)) pool_nxt[x] = NN; else head_p = NN;
        drop_node(tail_p);
        tail_p = x;
      end
      K_DEL_AFTER: if (is_node(cur_p) && cur_p != tail_p) begin
        n = pool_nxt[cur_p];
        x = pool_nxt[n];
        pool_nxt[cur_p] = x;
        if (is_node(x)) pool_prv[x] = cur_p; else tail_p = cur_p;
        drop_node(n);
      end
      K_DEL_BEFORE: if (is_node(cur_p) && cur_p != head_p) begin
        n = pool_prv[cur_p];
        x = pool_prv[n];
        pool_prv[cur_p] = x;
        if (is_node(x)) pool_nxt[x] = cur_p; else head_p = cur_p;
        drop_node(n);
      end
      K_INS_AFTER, K_INS_BEFORE: if (is_node(cur_p)) begin
        n = grab_node();
        if (!is_node(n)) r.pool_full_error = 1'b1;
        else begin
          pool_val[n] = v;
          if (k == K_INS_AFTER) begin
            x = pool_nxt[cur_p];
            pool_prv[n] = cur_p; pool_nxt[n] = x;
            if (is_node(x)) pool_prv[x] = n; else tail_p = n;
            pool_nxt[cur_p] = n;
          end else begin
            x = pool_prv[cur_p];
            pool_nxt[n] = cur_p; pool_prv[n] = x;
            if (is_node(x)) pool_nxt[x] = n; else head_p = n;
            pool_prv[cur_p] = n;
          end
        end
      end
      K_OVERWRITE: if (is_node(cur_p)) pool_val[cur_p] = v;
      K_NEXT: if (is_node(cur_p)) cur_p = pool_nxt[cur_p];
      K_PREV: if (is_node(cur_p)) cur_p = pool_prv[cur_p];
      default: ;
    endcase
    r.head_valid   = is_node(head_p);
    r.head_value   = is_node(head_p) ? pool_val[head_p] : '0;
    r.tail_value   = is_node(tail_p) ? pool_val[tail_p] : '0;
    r.cursor_valid = is_node(cur_p);
    r.cursor_value = is_node(cur_p) ? pool_val[cur_p] : '0;
    return r;
  endfunction

  // Random idle burst, sometimes none; valid drops only when idling
  task automatic maybe_idle();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Offer one transaction and wait until it is taken; pinned rows carry a typed result
  task automatic send_op(logic [3:0] k, logic [31:0] v, bit pinned, rsp_t want);
    rsp_t p;
    p = list_apply(k, v);
    if (pinned && p != want) begin
      $error("directed row disagrees with predictor: exp %h got %h", want, p);
      fail_n++;
    end
    pending_q.push_back(p);
    req_valid <= 1'b1;
    req.kind  <= k;
    req.value <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    maybe_idle();
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        rsp_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rsp_t w;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        fail_n++;
      end else begin
        w = pending_q.pop_front();
        if (rsp.pool_full_error !== w.pool_full_error) begin
          $error("pool_full_error exp %0d got %0d", w.pool_full_error, rsp.pool_full_error);
          fail_n++;
        end
        if (rsp.head_valid !== w.head_valid) begin
          $error("head_valid exp %0d got %0d", w.head_valid, rsp.head_valid);
          fail_n++;
        end
        if (rsp.head_value !== w.head_value) begin
          $error("head_value exp %0d got %0d", w.head_value, rsp.head_value);
          fail_n++;
        end
        if (rsp.tail_value !== w.tail_value) begin
          $error("tail_value exp %0d got %0d", w.tail_value, rsp.tail_value);
          fail_n++;
        end
        if (rsp.cursor_valid !== w.cursor_valid) begin
          $error("cursor_valid exp %0d got %0d", w.cursor_valid, rsp.cursor_valid);
          fail_n++;
        end
        if (rsp.cursor_value !== w.cursor_value) begin
          $error("cursor_value exp %0d got %0d", w.cursor_value, rsp.cursor_value);
          fail_n++;
        end
      end
    end
  end

  typedef struct {
    logic [3:0]  k;
    logic [31:0] v;
    bit          pinned;
    rsp_t        want;
  } step_row_t;

  localparam rsp_t EMPTY = '0;

  step_row_t dir_tab [] = '{
    '{K_READ,       32'h0,        1'b1, EMPTY},
    '{K_DEL_HEAD,   32'h0,        1'b1, EMPTY},
    '{K_DEL_TAIL,   32'h0,        1'b1, EMPTY},
    '{K_INS_AFTER,  32'h5,        1'b1, EMPTY},
    '{K_OVERWRITE,  32'h5,        1'b1, EMPTY},
    '{K_NEXT,       32'h0,        1'b1, EMPTY},
    '{K_CLEAR,      32'h0,        1'b1, EMPTY},
    '{K_INS_HEAD,   32'h7FFFFFFF, 1'b1,
      '{1'b0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h0}},
    '{K_INS_TAIL,   32'h80000000, 1'b1,
      '{1'b0, 1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b0, 32'h0}},
    '{K_CUR_HEAD,   32'h0,        1'b0, EMPTY},
    '{K_INS_BEFORE, 32'hFFFFFFFF, 1'b0, EMPTY},
    '{K_DEL_AFTER,  32'h0,        1'b0, EMPTY},
    '{K_CUR_TAIL,   32'h0,        1'b0, EMPTY},
    '{K_INS_AFTER,  32'h00000001, 1'b0, EMPTY},
    '{K_DEL_AFTER,  32'h0,        1'b0, EMPTY},
    '{K_PREV,       32'h0,        1'b0, EMPTY},
    '{K_DEL_BEFORE, 32'h0,        1'b0, EMPTY},
    '{K_OVERWRITE,  32'hA5A5A5A5, 1'b0, EMPTY},
    '{K_DEL_BEFORE, 32'h0,        1'b0, EMPTY},
    '{K_NEXT,       32'h0,        1'b0, EMPTY},
    '{K_PREV,       32'h0,        1'b0, EMPTY},
    '{K_CUR_TAIL,   32'h0,        1'b0, EMPTY},
    '{K_DEL_TAIL,   32'h0,        1'b0, EMPTY},
    '{4'd15,        32'h0,        1'b0, EMPTY},
    '{K_CLEAR,      32'h0,        1'b0, EMPTY}
  };

  // Biased random operation: heavy on inserts while the list is short
  function automatic logic [3:0] pick_kind(int fill);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return K_CLEAR;
    if (r < 3) return 4'd15;
    if (fill < 8 && r < 40) return 4'($urandom_range(K_INS_HEAD, K_INS_TAIL));
    if (r < 20) return 4'($urandom_range(K_INS_HEAD, K_INS_TAIL));
    if (r < 32) return 4'($urandom_range(K_INS_AFTER, K_INS_BEFORE));
    if (r < 42) return 4'($urandom_range(K_CUR_HEAD, K_CUR_TAIL));
    if (r < 60) return 4'($urandom_range(K_NEXT, K_PREV));
    return 4'($urandom_range(K_DEL_HEAD, K_READ));
  endfunction

  initial begin
    int i;
    head_p = NN; tail_p = NN; cur_p = NN; free_p = NN; fresh_n = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[j]) send_op(dir_tab[j].k, dir_tab[j].v, dir_tab[j].pinned, dir_tab[j].want);

    // Fill past capacity at both ends and beside the cursor to hit pool-full
    for (i = 0; i < NN + 3; i++) send_op(i[0] ? K_INS_TAIL : K_INS_HEAD, $urandom(), 1'b0, EMPTY);
    send_op(K_CUR_HEAD, 32'h0, 1'b0, EMPTY);
    send_op(K_INS_AFTER, $urandom(), 1'b0, EMPTY);
    send_op(K_INS_BEFORE, $urandom(), 1'b0, EMPTY);
    send_op(K_CLEAR, 32'h0, 1'b0, EMPTY);

    // Sender pause until all results are back
    drain();

    // Long receiver hold-off while requests keep coming
    hold_rx = 1'b1;
    for (i = 0; i < 20; i++) send_op(pick_kind(list_len()), $urandom(), 1'b0, EMPTY);

    for (i = 0; i < 1150; i++) begin
      if (i == 1000) no_idle = 1'b1;
      send_op(pick_kind(list_len()), $urandom(), 1'b0, EMPTY);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_n == 0 && pending_q.size() == 0) begin
      $display("PASS doubly_linked_list_with_cursor");
    end else begin
      $display("FAIL doubly_linked_list_with_cursor");
    end
    $finish;
  end
endmodule
